/* rtl/bzci_pkg.sv */
// shared types and constants for the binned z correction interpolator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bzci_pkg;

   localparam int DEF_R2_BINS = 16;
   localparam int DEF_Z_BINS  = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_CORRECT = 1'b1;

   typedef enum logic [2:0] {
      CSR_R2_LOWER     = 3'd0,
      CSR_R2_UPPER     = 3'd1,
      CSR_R2_BIN_WIDTH = 3'd2,
      CSR_Z_LOWER      = 3'd3,
      CSR_Z_UPPER      = 3'd4,
      CSR_Z_BIN_WIDTH  = 3'd5,
      CSR_CENTRAL_BAND = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [23:0]        r2_lower;
      logic [23:0]        r2_upper;
      logic [23:0]        r2_bin_width;
      logic signed [15:0] z_lower;
      logic signed [15:0] z_upper;
      logic [14:0]        z_bin_width;
      logic [14:0]        central_band;
   } cfg_type;

   typedef struct packed {
      logic               load;
      logic               bypass;
      logic               in_range;
      logic signed [15:0] rz;
      logic [23:0]        rr2;
      logic [3:0]         ld_r2;
      logic [3:0]         ld_z;
      logic [17:0]        ld_factor;
      logic [23:0]        r2_off;
      logic [16:0]        z_off;
   } item_type;

endpackage
`default_nettype wire

/* rtl/binned_z_correction_interpolator.sv */
// Binned z correction interpolator, top level.
// Requests come in on req_ (tuser = func: 0 loads one table word, 1 corrects
// a position). A load writes one factor and gives no response; a correction
// gives one response on rsp_ with the corrected z, rec_r2 passed through and
// the in_range flag in tuser. Out-of-range positions pass through with
// in_range low; inside the central band z passes through with in_range high.
// The csr_ channel writes the axis registers by index; csr_ready is always
// high. The user must make writes only while the block is idle; the block
// does not enforce it. Throughput is one request per cycle while rsp_tready
// does not hold the back pipeline. The two pipelined divide units are a 24
// stage bin index divider and a KW stage rounding divider (KW = 43 with 16
// z bins). A 4 entry queue parts the front from the back, so requests keep
// flowing while a response waits. When rsp_tready is low the back pipeline
// holds, the queue fills and then req_tready drops. Reset clears all valid
// state and presets the axis registers; the table is undefined until loaded.
// depends on bzci_pkg, bzci_front, bzci_fifo, bzci_back
`timescale 1ns / 1ps
`default_nettype none
module binned_z_correction_interpolator
   import bzci_pkg::*;
#(
   parameter int R2_BINS = DEF_R2_BINS,
   parameter int Z_BINS  = DEF_Z_BINS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // load_r2_index[3:0], load_z_index[7:4], load_factor[25:8], rec_z[41:26],
   // rec_r2[65:42], zero fill
   input  wire logic [71:0] req_tdata,
   // func
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // true_z[17:0], true_r2[41:18], zero fill
   output logic [47:0]      rsp_tdata,
   // in_range
   output logic             rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   cfg_type  cfg_ff;
   logic     push, q_not_full, q_not_empty, pop;
   item_type push_item, head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.r2_lower     <= 24'd0;
         cfg_ff.r2_upper     <= 24'hFFFFFF;
         cfg_ff.r2_bin_width <= 24'd1048576;
         cfg_ff.z_lower      <= -16'sd32768;
         cfg_ff.z_upper      <= 16'sd32767;
         cfg_ff.z_bin_width  <= 15'd4096;
         cfg_ff.central_band <= 15'd6400;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_R2_LOWER:     cfg_ff.r2_lower     <= csr_data;
            CSR_R2_UPPER:     cfg_ff.r2_upper     <= csr_data;
            CSR_R2_BIN_WIDTH: cfg_ff.r2_bin_width <= csr_data;
            CSR_Z_LOWER:      cfg_ff.z_lower      <= csr_data[15:0];
            CSR_Z_UPPER:      cfg_ff.z_upper      <= csr_data[15:0];
            CSR_Z_BIN_WIDTH:  cfg_ff.z_bin_width  <= csr_data[14:0];
            CSR_CENTRAL_BAND: cfg_ff.central_band <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   bzci_front u_front (
      .clock, .reset, .cfg(cfg_ff), .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .push, .push_item, .q_not_full
   );

   bzci_fifo u_queue (
      .clock, .reset, .push, .push_item, .not_full(q_not_full), .pop,
      .not_empty(q_not_empty), .head
   );

   bzci_back #(.R2_BINS(R2_BINS), .Z_BINS(Z_BINS)) u_back (
      .clock, .reset, .cfg(cfg_ff), .q_not_empty, .head, .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

endmodule
`default_nettype wire

/* rtl/bzci_fifo.sv */
// short request queue between the front and back parts
// depends on bzci_pkg
`timescale 1ns / 1ps
`default_nettype none
module bzci_fifo
   import bzci_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          not_full,
   input  wire logic     pop,
   output logic          not_empty,
   output item_type      head
);

   localparam int PTRW = $clog2(QUEUE_DEPTH);

   item_type        q_ff [QUEUE_DEPTH];
   logic [PTRW-1:0] wp_ff, wp_in;
   logic [PTRW-1:0] rp_ff, rp_in;
   logic [PTRW:0]   cnt_ff, cnt_in;

   assign not_full  = cnt_ff != (PTRW+1)'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (PTRW+1)'(push) - (PTRW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* rtl/bzci_div.sv */
// pipelined restoring divider, one quotient bit per stage, with sideband
// standalone, no package use
`timescale 1ns / 1ps
`default_nettype none
module bzci_div #(
   parameter int NW = 24,
   parameter int DW = 24,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_num,
   input  wire logic [DW-1:0] den,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [NW-1:0]      out_quo,
   output logic [SW-1:0]      out_side
);

   logic          v_ff    [NW];
   logic [DW-1:0] rem_ff  [NW];
   logic [NW-1:0] num_ff  [NW];
   logic [SW-1:0] side_ff [NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic          sv;
      logic [DW-1:0] srem;
      logic [NW-1:0] snum;
      logic [SW-1:0] sside;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] num_in;

      if (s == 0) begin : g_first
         assign sv    = in_valid;
         assign srem  = '0;
         assign snum  = in_num;
         assign sside = in_side;
      end else begin : g_next
         assign sv    = v_ff[s-1];
         assign srem  = rem_ff[s-1];
         assign snum  = num_ff[s-1];
         assign sside = side_ff[s-1];
      end

      // numerator bits shift out on top, quotient bits shift in below
      always_comb begin
         trial  = {srem, snum[NW-1]};
         ge     = trial >= {1'b0, den};
         rem_in = ge ? DW'(trial - {1'b0, den}) : DW'(trial);
         num_in = {snum[NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= sv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            num_ff[s]  <= num_in;
            side_ff[s] <= sside;
         end
      end
   end

   assign out_valid = v_ff[NW-1];
   assign out_quo   = num_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule
`default_nettype wire

/* rtl/bzci_front.sv */
// front part: takes requests, range and central band checks, axis offsets
// depends on bzci_pkg
`timescale 1ns / 1ps
`default_nettype none
module bzci_front
   import bzci_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,
   input  wire logic        req_tuser,
   output logic             push,
   output item_type         push_item,
   input  wire logic        q_not_full
);

   logic               v_ff;
   item_type           item_ff, item_in;
   logic signed [15:0] rz;
   logic [23:0]        rr2;
   logic [15:0]        rz_mag;
   logic               out_range;
   logic               adv;

   assign adv        = !v_ff || q_not_full;
   assign req_tready = adv;
   assign push       = v_ff && q_not_full;
   assign push_item  = item_ff;

   always_comb begin
      rz        = $signed(req_tdata[41:26]);
      rr2       = req_tdata[65:42];
      rz_mag    = rz[15] ? 16'(-rz) : 16'(rz);
      out_range = (rr2 < cfg.r2_lower) || (rr2 > cfg.r2_upper) ||
                  (rz < cfg.z_lower) || (rz > cfg.z_upper);
      item_in.load      = req_tuser == FUNC_LOAD;
      item_in.in_range  = !out_range;
      item_in.bypass    = out_range || (rz_mag < {1'b0, cfg.central_band});
      item_in.rz        = rz;
      item_in.rr2       = rr2;
      item_in.ld_r2     = req_tdata[3:0];
      item_in.ld_z      = req_tdata[7:4];
      item_in.ld_factor = req_tdata[25:8];
      item_in.r2_off    = rr2 - cfg.r2_lower;
      item_in.z_off     = 17'($signed({rz[15], rz}) - $signed({cfg.z_lower[15], cfg.z_lower}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && req_tvalid) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/bzci_back.sv */
// back part: bin division, table, interpolation, scaling, rounding, output
// depends on bzci_pkg and bzci_div
`timescale 1ns / 1ps
`default_nettype none
module bzci_back
   import bzci_pkg::*;
#(
   parameter int R2_BINS = DEF_R2_BINS,
   parameter int Z_BINS  = DEF_Z_BINS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        q_not_empty,
   input  wire item_type    head,
   output logic             pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tuser
);

   localparam int RIW = (R2_BINS > 1) ? $clog2(R2_BINS) : 1;
   localparam int ZIW = $clog2(Z_BINS);
   localparam int TW  = R2_BINS * Z_BINS;
   localparam int AW  = $clog2(TW);
   localparam int CW  = ZIW + 18;
   localparam int KW  = CW + 21;
   localparam int HW  = KW - 24;
   localparam int PW  = KW + 17;
   localparam int IW  = $bits(item_type);

   logic        adv;
   logic [23:0] rw_eff;
   logic [14:0] zw_eff;

   assign rw_eff = (cfg.r2_bin_width == '0) ? 24'd1 : cfg.r2_bin_width;
   assign zw_eff = (cfg.z_bin_width == '0) ? 15'd1 : cfg.z_bin_width;

   logic rsp_v_ff;
   assign adv = !rsp_v_ff || rsp_tready;
   assign pop = adv && q_not_empty;

   // bin indices
   logic          dv_r, dv_z;
   logic [23:0]   r_q, z_q;
   logic [IW-1:0] d_side;
   logic          z_side_unused;

   bzci_div #(.NW(24), .DW(24), .SW(IW)) u_div_r2 (
      .clock, .reset, .en(adv), .in_valid(q_not_empty), .in_num(head.r2_off),
      .den(rw_eff), .in_side(head), .out_valid(dv_r), .out_quo(r_q), .out_side(d_side)
   );

   bzci_div #(.NW(24), .DW(24), .SW(1)) u_div_z (
      .clock, .reset, .en(adv), .in_valid(q_not_empty), .in_num({7'd0, head.z_off}),
      .den({9'd0, zw_eff}), .in_side(1'b0), .out_valid(dv_z), .out_quo(z_q),
      .out_side(z_side_unused)
   );

   // t1: clamp, odd multiple of bin width
   logic            t1_v_ff;
   item_type        t1_item_ff;
   logic [RIW-1:0]  t1_ri_ff, t1_ri_in;
   logic [ZIW-1:0]  t1_zi_ff, t1_zi_in;
   logic [ZIW+15:0] t1_cen_ff, t1_cen_in;

   always_comb begin
      t1_ri_in  = (r_q > 24'(R2_BINS - 1)) ? RIW'(R2_BINS - 1) : r_q[RIW-1:0];
      t1_zi_in  = (z_q > 24'(Z_BINS - 1)) ? ZIW'(Z_BINS - 1) : z_q[ZIW-1:0];
      t1_cen_in = (ZIW+16)'({t1_zi_in, 1'b1}) * (ZIW+16)'(zw_eff);
   end

   // t2: distance from the bin centre, neighbour choice, table addresses
   logic                  t2_v_ff;
   item_type              t2_item_ff;
   logic [CW-1:0]         t2_dmag_ff, t2_dmag_in;
   logic                  t2_nb_ff, t2_nb_in;
   logic [AW-1:0]         t2_ac_ff, t2_ac_in;
   logic [AW-1:0]         t2_an_ff, t2_an_in;
   logic signed [CW-1:0]  cen2;
   logic signed [CW:0]    dz2;
   logic [ZIW-1:0]        nz;
   logic                  pos;

   always_comb begin
      cen2 = CW'($signed({cfg.z_lower, 1'b0})) + CW'($signed({1'b0, t1_cen_ff}));
      dz2  = (CW+1)'($signed({t1_item_ff.rz, 1'b0})) - (CW+1)'(cen2);
      pos  = dz2 > 0;
      t2_dmag_in = dz2[CW] ? CW'(-dz2) : CW'(dz2);
      nz   = pos ? t1_zi_ff + 1'b1 : t1_zi_ff - 1'b1;
      t2_nb_in = pos ? (t1_zi_ff != ZIW'(Z_BINS - 1)) : (t1_zi_ff != '0);
      t2_ac_in = AW'(AW'(t1_ri_ff) * AW'(Z_BINS) + AW'(t1_zi_ff));
      t2_an_in = AW'(AW'(t1_ri_ff) * AW'(Z_BINS) + AW'(nz));
   end

   // load address of a table write
   logic          ld_ok;
   logic [AW-1:0] ld_addr;

   always_comb begin
      ld_ok   = (32'(t2_item_ff.ld_r2) < R2_BINS) && (32'(t2_item_ff.ld_z) < Z_BINS);
      ld_addr = AW'(AW'(t2_item_ff.ld_r2) * AW'(Z_BINS) + AW'(t2_item_ff.ld_z));
   end

   // t3: table read, and the table write of a load
   logic [17:0]   mem [TW];
   logic          t3_v_ff;
   item_type      t3_item_ff;
   logic [17:0]   t3_c_ff, t3_n_ff;
   logic          t3_nb_ff;
   logic [CW-1:0] t3_dmag_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (t2_v_ff && t2_item_ff.load && ld_ok) begin
            mem[ld_addr] <= t2_item_ff.ld_factor;
         end
         t3_c_ff <= mem[t2_ac_ff];
         t3_n_ff <= mem[t2_an_ff];
      end
   end

   // m1: both interpolation products
   logic                  m1_v_ff;
   item_type              m1_item_ff;
   logic [33:0]           m1_p1_ff, m1_p1_in;
   logic signed [CW+19:0] m1_p2_ff, m1_p2_in;
   logic [17:0]           nval;
   logic signed [18:0]    diff;

   always_comb begin
      nval     = t3_nb_ff ? t3_n_ff : t3_c_ff;
      diff     = $signed({1'b0, nval}) - $signed({1'b0, t3_c_ff});
      m1_p1_in = 34'(t3_c_ff) * 34'({zw_eff, 1'b0});
      m1_p2_in = (CW+20)'($signed({1'b0, t3_dmag_ff})) * (CW+20)'(diff);
   end

   // m2: interpolated factor times 2w, sign and magnitude
   logic                 m2_v_ff;
   item_type             m2_item_ff;
   logic [KW-1:0]        m2_cmag_ff, m2_cmag_in;
   logic                 m2_neg_ff, m2_neg_in;
   logic [15:0]          m2_zmag_ff, m2_zmag_in;
   logic signed [KW-1:0] corr;

   always_comb begin
      corr       = KW'($signed({1'b0, m1_p1_ff})) + KW'(m1_p2_ff);
      m2_cmag_in = corr[KW-1] ? KW'(-corr) : KW'(corr);
      m2_neg_in  = m1_item_ff.rz[15] ^ corr[KW-1];
      m2_zmag_in = m1_item_ff.rz[15] ? 16'(-m1_item_ff.rz) : 16'(m1_item_ff.rz);
   end

   // m3: z times factor, split into two partial products
   logic          m3_v_ff;
   item_type      m3_item_ff;
   logic          m3_neg_ff;
   logic [39:0]   m3_lo_ff, m3_lo_in;
   logic [HW+15:0] m3_hi_ff, m3_hi_in;

   always_comb begin
      m3_lo_in = 40'(m2_zmag_ff) * 40'(m2_cmag_ff[23:0]);
      m3_hi_in = (HW+16)'(m2_zmag_ff) * (HW+16)'(m2_cmag_ff[KW-1:24]);
   end

   // m4: sum, add half the divisor, drop the 2^17 part of the divisor
   logic          m4_v_ff;
   item_type      m4_item_ff;
   logic          m4_neg_ff;
   logic [KW-1:0] m4_sh_ff;
   logic [PW-1:0] prod;

   always_comb begin
      prod = PW'(m3_lo_ff) + (PW'(m3_hi_ff) << 24) + (PW'(zw_eff) << 16);
   end

   logic          fv;
   logic [KW-1:0] fq;
   logic [IW:0]   f_side;
   item_type      f_item;
   logic          f_neg;

   bzci_div #(.NW(KW), .DW(15), .SW(IW + 1)) u_div_out (
      .clock, .reset, .en(adv), .in_valid(m4_v_ff), .in_num(m4_sh_ff), .den(zw_eff),
      .in_side({m4_neg_ff, m4_item_ff}), .out_valid(fv), .out_quo(fq), .out_side(f_side)
   );

   logic signed [17:0] tz;

   always_comb begin
      f_item = f_side[IW-1:0];
      f_neg  = f_side[IW];
      if (f_item.bypass) begin
         tz = 18'(f_item.rz);
      end else if (f_neg) begin
         tz = (fq > KW'(131072)) ? -18'sd131072 : 18'(-$signed({1'b0, fq}));
      end else begin
         tz = (fq > KW'(131071)) ? 18'sd131071 : 18'(fq);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff  <= 1'b0;
         t2_v_ff  <= 1'b0;
         t3_v_ff  <= 1'b0;
         m1_v_ff  <= 1'b0;
         m2_v_ff  <= 1'b0;
         m3_v_ff  <= 1'b0;
         m4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         t1_v_ff  <= dv_r && dv_z;
         t2_v_ff  <= t1_v_ff;
         t3_v_ff  <= t2_v_ff;
         m1_v_ff  <= t3_v_ff;
         m2_v_ff  <= m1_v_ff;
         m3_v_ff  <= m2_v_ff;
         m4_v_ff  <= m3_v_ff;
         rsp_v_ff <= fv && !f_item.load;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_item_ff <= d_side;
         t1_ri_ff   <= t1_ri_in;
         t1_zi_ff   <= t1_zi_in;
         t1_cen_ff  <= t1_cen_in;
         t2_item_ff <= t1_item_ff;
         t2_dmag_ff <= t2_dmag_in;
         t2_nb_ff   <= t2_nb_in;
         t2_ac_ff   <= t2_ac_in;
         t2_an_ff   <= t2_an_in;
         t3_item_ff <= t2_item_ff;
         t3_nb_ff   <= t2_nb_ff;
         t3_dmag_ff <= t2_dmag_ff;
         m1_item_ff <= t3_item_ff;
         m1_p1_ff   <= m1_p1_in;
         m1_p2_ff   <= m1_p2_in;
         m2_item_ff <= m1_item_ff;
         m2_cmag_ff <= m2_cmag_in;
         m2_neg_ff  <= m2_neg_in;
         m2_zmag_ff <= m2_zmag_in;
         m3_item_ff <= m2_item_ff;
         m3_neg_ff  <= m2_neg_ff;
         m3_lo_ff   <= m3_lo_in;
         m3_hi_ff   <= m3_hi_in;
         m4_item_ff <= m3_item_ff;
         m4_neg_ff  <= m3_neg_ff;
         m4_sh_ff   <= prod[PW-1:17];
         rsp_tdata  <= {6'd0, f_item.rr2, tz};
         rsp_tuser  <= f_item.in_range;
      end
   end

   assign rsp_tvalid = rsp_v_ff;

endmodule
`default_nettype wire

/* test/bzci_checker.sv */
// response checker for the binned z correction interpolator
// predicts each correction from its own copy of the table and registers
// depends on bzci_pkg
`timescale 1ns / 1ps
module bzci_checker
   import bzci_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data,
   output int               fail_count,
   output int               pending
);

   typedef struct packed {
      logic [17:0] tz;
      logic [23:0] r2;
      logic        inr;
   } corr_type;

   cfg_type     axes;
   logic [17:0] factors [0:255];
   corr_type    corr_q[$];

   assign pending = corr_q.size();

   function automatic longint round_div(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
   endfunction

   function automatic corr_type correct_z(logic signed [15:0] rz, logic [23:0] r2);
      corr_type c;
      longint   rw, zw, ri, zi, cen2, d, cv, nv, nz, tz, zl, mag;
      c.r2 = r2;
      c.tz = 18'(longint'(rz));
      c.inr = 1'b0;
      zl = longint'(axes.z_lower);
      if (r2 < axes.r2_lower || r2 > axes.r2_upper || rz < axes.z_lower ||
          rz > axes.z_upper)
         return c;
      c.inr = 1'b1;
      mag = (rz < 0) ? -longint'(rz) : longint'(rz);
      if (mag < longint'(axes.central_band))
         return c;
      rw = (axes.r2_bin_width == 0) ? 1 : longint'(axes.r2_bin_width);
      zw = (axes.z_bin_width == 0) ? 1 : longint'(axes.z_bin_width);
      ri = (longint'(r2) - longint'(axes.r2_lower)) / rw;
      zi = (longint'(rz) - zl) / zw;
      if (ri > 15) ri = 15;
      if (zi > 15) zi = 15;
      cen2 = 2 * zl + (2 * zi + 1) * zw;
      d = 2 * longint'(rz) - cen2;
      nz = (d > 0) ? zi + 1 : zi - 1;
      if (d < 0) d = -d;
      cv = factors[ri * 16 + zi];
      nv = (nz < 0 || nz > 15) ? cv : longint'(factors[ri * 16 + nz]);
      tz = round_div(longint'(rz) * (cv * 2 * zw + d * (nv - cv)), 2 * zw * 65536);
      if (tz > 131071) tz = 131071;
      if (tz < -131072) tz = -131072;
      c.tz = 18'(tz);
      return c;
   endfunction

   always @(posedge clock) begin
      corr_type got, want;
      if (reset) begin
         axes.r2_lower <= 24'd0;
         axes.r2_upper <= 24'hFFFFFF;
         axes.r2_bin_width <= 24'd1048576;
         axes.z_lower <= -16'sd32768;
         axes.z_upper <= 16'sd32767;
         axes.z_bin_width <= 15'd4096;
         axes.central_band <= 15'd6400;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_R2_LOWER:     axes.r2_lower <= csr_data;
               CSR_R2_UPPER:     axes.r2_upper <= csr_data;
               CSR_R2_BIN_WIDTH: axes.r2_bin_width <= csr_data;
               CSR_Z_LOWER:      axes.z_lower <= csr_data[15:0];
               CSR_Z_UPPER:      axes.z_upper <= csr_data[15:0];
               CSR_Z_BIN_WIDTH:  axes.z_bin_width <= csr_data[14:0];
               CSR_CENTRAL_BAND: axes.central_band <= csr_data[14:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == FUNC_LOAD)
               factors[{req_tdata[3:0], req_tdata[7:4]}] <= req_tdata[25:8];
            else
               corr_q.push_back(correct_z(req_tdata[41:26], req_tdata[65:42]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[17:0], rsp_tdata[41:18], rsp_tuser};
            if (corr_q.size() == 0) begin
               $error("response with no correction pending");
               fail_count <= fail_count + 1;
            end else begin
               want = corr_q.pop_front();
               if (got.tz !== want.tz)
                  $error("true_z expected %0d actual %0d", $signed(want.tz), $signed(got.tz));
               if (got.r2 !== want.r2)
                  $error("true_r2 expected %0d actual %0d", want.r2, got.r2);
               if (got.inr !== want.inr)
                  $error("in_range expected %0d actual %0d", want.inr, got.inr);
               if (got !== want)
                  fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

/* test/tb_top.sv */
// stimulus top for the binned z correction interpolator
// drives requests and csr writes, stalls responses; depends on bzci_pkg, bzci_checker
`timescale 1ns / 1ps
module tb_top;
   import bzci_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          hold_off = 0;

   binned_z_correction_interpolator i_dut (.*);
   bzci_checker i_check (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   // valid stays high between back to back requests
   task automatic send_req(logic fn, logic [3:0] a, logic [3:0] b, logic [17:0] f,
                           logic [15:0] z, logic [23:0] r2);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {6'd0, r2, z, f, b, a};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_table();
      for (int i = 0; i < 256; i++)
         send_req(FUNC_LOAD, i[7:4], i[3:0], 18'($urandom), 16'($urandom), 24'($urandom));
   endtask

   task automatic write_csr(csr_index_type idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic rand_correct();
      logic [15:0] z;
      logic [23:0] r2;
      z = 16'($urandom);
      r2 = 24'($urandom);
      if ($urandom_range(0, 3) == 0)
         send_req(FUNC_LOAD, 4'($urandom), 4'($urandom), 18'($urandom), z, r2);
      else
         send_req(FUNC_CORRECT, 4'($urandom), 4'($urandom), 18'($urandom), z, r2);
   endtask

   // response side: a drawn wait per response plus one long hold-off
   initial begin
      int rsp_wait;
      rsp_wait = 0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            hold_off = hold_off - 1;
         end else if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait = rsp_wait - 1;
         end else if (rsp_tready && rsp_tvalid) begin
            rsp_wait = $urandom_range(0, 5);
            rsp_tready <= (rsp_wait == 0);
            if (rsp_wait > 0)
               rsp_wait = rsp_wait - 1;
         end else
            rsp_tready <= 1'b1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      load_table();
      // directed: extremes, band edges, out of range, last bins
      send_req(FUNC_CORRECT, 0, 0, 0, 16'h8000, 24'd0);
      send_req(FUNC_CORRECT, 0, 0, 0, 16'h7FFF, 24'hFFFFFF);
      send_req(FUNC_CORRECT, 0, 0, 0, 16'd6399, 24'd5);
      send_req(FUNC_CORRECT, 0, 0, 0, 16'd6400, 24'd5);
      send_req(FUNC_CORRECT, 0, 0, 0, -16'sd6400, 24'd5);
      send_req(FUNC_CORRECT, 0, 0, 0, 16'd0, 24'd0);
      send_req(FUNC_CORRECT, 0, 0, 0, 16'hFFFF, 24'h800000);
      send_req(FUNC_LOAD, 4'hF, 4'hF, 18'h3FFFF, 16'hFFFF, 24'hFFFFFF);
      send_req(FUNC_CORRECT, 0, 0, 0, 16'h7FF0, 24'hFFFFFF);
      drain();
      write_csr(CSR_R2_LOWER, 24'd1000);
      write_csr(CSR_R2_UPPER, 24'd500000);
      write_csr(CSR_R2_BIN_WIDTH, 24'd0);
      write_csr(CSR_Z_LOWER, 24'h00F000);
      write_csr(CSR_Z_UPPER, 24'h001000);
      write_csr(CSR_Z_BIN_WIDTH, 24'd0);
      write_csr(CSR_CENTRAL_BAND, 24'd0);
      send_req(FUNC_CORRECT, 0, 0, 0, 16'h0800, 24'd999);
      send_req(FUNC_CORRECT, 0, 0, 0, 16'h0800, 24'd1000);
      send_req(FUNC_CORRECT, 0, 0, 0, 16'h1001, 24'd2000);
      send_req(FUNC_CORRECT, 0, 0, 0, 16'hF000, 24'd500000);
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         write_csr(CSR_R2_LOWER, (phase == 3) ? 24'hFFFFFF : 24'($urandom_range(0, 4000000)));
         write_csr(CSR_R2_UPPER, (phase == 0) ? 24'hFFFFFF : 24'($urandom_range(8000000, 16777215)));
         write_csr(CSR_R2_BIN_WIDTH, (phase == 1) ? 24'hFFFFFF : 24'($urandom_range(1, 1000000)));
         write_csr(CSR_Z_LOWER, (phase == 2) ? 24'h008000 : 24'($urandom_range(32768, 65535)));
         write_csr(CSR_Z_UPPER, (phase == 2) ? 24'h007FFF : 24'($urandom_range(0, 32767)));
         write_csr(CSR_Z_BIN_WIDTH, (phase == 1) ? 24'h7FFF : 24'($urandom_range(1, 8000)));
         write_csr(CSR_CENTRAL_BAND, (phase == 0) ? 24'h7FFF : 24'($urandom_range(0, 3000)));
         if (phase == 1) begin
            hold_off = 300;
            repeat (30) send_req(FUNC_CORRECT, 0, 0, 0, 16'($urandom), 24'($urandom));
         end
         repeat (100) rand_correct();
      end
      drain();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
